/* src/ptdt_pkg.sv */
// Shared constants and word types for the periodic task deadline table.
package ptdt_pkg;

    localparam int NUM_TASKS_DEF   = 16;
    localparam int TIMER_WIDTH_DEF = 32;
    localparam int INDEX_W         = 4;
    localparam int VALUE_W         = 32;

    localparam logic [1:0] OP_POLL   = 2'd0;
    localparam logic [1:0] OP_ENABLE = 2'd1;
    localparam logic [1:0] OP_PERIOD = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] task_index;
        logic [VALUE_W-1:0] now;
        logic               enable_value;
        logic [VALUE_W-1:0] period_value;
    } cmd_t;

    typedef struct packed {
        logic               fired;
        logic [VALUE_W-1:0] elapsed;
    } result_t;

endpackage

/* src/periodic_task_deadline_table.sv */
// Top level of the periodic task deadline table.
//
//  Channel   Handshake          Word                Notes
//  command   start / busy       cmd (cmd_t)         taken when start is high and busy low
//  result    done (strobe)      result (result_t)   shown for exactly one cycle
//
// A poll that fires shows its result after the remainder unit has run, one dividend
// bit per cycle; every other word reads its entry in ST_READ and registers its result
// from there, and no new word is taken while busy is high.
// The entry memory is read at the accepting edge and written at most once per word.
// Reset clears the enable bits and the control state; no clearing pass is needed.
// The receiver cannot stall; busy stays high until the result is shown.
module periodic_task_deadline_table #(
    parameter int NUM_TASKS   = ptdt_pkg::NUM_TASKS_DEF,
    parameter int TIMER_WIDTH = ptdt_pkg::TIMER_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ptdt_pkg::cmd_t    cmd,
    output logic              done,
    output ptdt_pkg::result_t result
);

    import ptdt_pkg::*;

    localparam int TW = TIMER_WIDTH;
    localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int XW = (TW > VALUE_W) ? TW : VALUE_W;
    localparam int EW = VALUE_W + TW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [EW-1:0]     entry_mem [NUM_TASKS];
    logic [EW-1:0]     rd_data_reg;
    logic [NUM_TASKS-1:0] en_bits_reg;

    logic [1:0]        op_reg;
    logic [AW-1:0]     idx_reg;
    logic              inr_reg;
    logic [TW-1:0]     now_reg;
    logic              en_reg;
    logic [VALUE_W-1:0] pv_reg;
    logic [TW-1:0]     delta_reg;

    logic              done_reg;
    result_t           res_reg;

    logic              in_range;
    logic              mem_rd;
    logic              mem_we;
    logic [EW-1:0]     wr_data;
    logic              en_we;
    logic              div_start;
    logic              div_done;
    logic [TW-1:0]     div_rem;
    logic              res_issue;
    logic              res_fire;

    logic [VALUE_W-1:0] per_rd;
    logic [VALUE_W-1:0] per_eff;
    logic [TW-1:0]     stamp_rd;
    logic [TW-1:0]     delta;
    logic              hit;

    assign in_range = (int'(cmd.task_index) < NUM_TASKS);
    assign per_rd   = rd_data_reg[EW-1:TW];
    assign stamp_rd = rd_data_reg[TW-1:0];
    assign per_eff  = (per_rd == '0) ? VALUE_W'(1) : per_rd;
    assign delta    = now_reg - stamp_rd;
    assign hit      = (XW'(delta) >= XW'(per_eff));

    always_comb
    begin
        state_next = state_reg;
        mem_rd     = 1'b0;
        mem_we     = 1'b0;
        wr_data    = rd_data_reg;
        en_we      = 1'b0;
        div_start  = 1'b0;
        res_issue  = 1'b0;
        res_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mem_rd     = in_range;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                res_issue  = 1'b1;
                if (inr_reg)
                begin
                    unique case (op_reg)
                        OP_POLL:
                        begin
                            if (en_bits_reg[idx_reg] && hit)
                            begin
                                div_start  = 1'b1;
                                res_issue  = 1'b0;
                                state_next = ST_DIV;
                            end
                        end
                        OP_ENABLE:
                        begin
                            mem_we  = 1'b1;
                            en_we   = 1'b1;
                            wr_data = {per_rd, TW'(XW'(now_reg) - XW'(per_rd))};
                        end
                        OP_PERIOD:
                        begin
                            mem_we  = 1'b1;
                            en_we   = 1'b1;
                            wr_data = {((pv_reg == '0) ? VALUE_W'(1) : pv_reg), {TW{1'b0}}};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    wr_data    = {per_rd, now_reg - div_rem};
                    res_issue  = 1'b1;
                    res_fire   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            en_bits_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_issue;
            if (en_we)
            begin
                en_bits_reg[idx_reg] <= en_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg  <= cmd.operation;
            idx_reg <= AW'(cmd.task_index);
            inr_reg <= in_range;
            now_reg <= TW'(cmd.now);
            en_reg  <= cmd.enable_value;
            pv_reg  <= cmd.period_value;
        end
        if (div_start)
        begin
            delta_reg <= delta;
        end
        if (res_issue)
        begin
            res_reg.fired   <= res_fire;
            res_reg.elapsed <= res_fire ? VALUE_W'(delta_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= entry_mem[AW'(cmd.task_index)];
        end
        if (mem_we)
        begin
            entry_mem[idx_reg] <= wr_data;
        end
    end

    ptdt_rem #(
        .W (TW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (delta),
        .divisor   (TW'(per_eff)),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_div_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> inr_reg && op_reg == OP_POLL)
        else $error("Remainder phase entered for a word that is not a valid poll.");

    a_fire_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.fired |-> $past(state_reg == ST_DIV))
        else $error("A firing result appeared without a remainder phase.");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ST_IDLE && inr_reg)
        else $error("Entry memory written outside a valid word.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done_reg)
        else $error("Accepted word did not raise busy.");

endmodule

/* src/ptdt_rem.sv */
// Iterative restoring remainder unit, one dividend bit per cycle.
module ptdt_rem #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  dvd_reg;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (diff[W])
        begin
            rem_next = trial[W-1:0];
        end
        else
        begin
            rem_next = diff[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dvs_reg)
        else $error("Remainder is not below the divisor.");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("Remainder unit restarted while running.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("Remainder done held for more than one cycle.");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the periodic task deadline table.
module tb_top;

    import ptdt_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          TASKS        = NUM_TASKS_DEF;
    localparam int          DRAIN_CYCLES = TIMER_WIDTH_DEF + 8;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          REPORT_MAX   = 10;
    localparam logic [1:0]  OP_RESERVED  = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    logic [VALUE_W-1:0] task_period [TASKS];
    logic [VALUE_W-1:0] task_stamp [TASKS];
    bit                 task_enabled [TASKS];
    bit                 period_known [TASKS];

    result_t            awaited_outcomes [$];
    result_t            want;
    logic [VALUE_W-1:0] wall_clock;

    int cycle_count = 0;
    int fail_count = 0;
    int results_checked = 0;
    int polls_sent = 0;
    int fires_predicted = 0;
    int enables_sent = 0;
    int periods_sent = 0;
    int reserved_sent = 0;

    periodic_task_deadline_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic log_failure(input string what, input result_t exp, input result_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("Mismatch (%s) at cycle %0d: expected fired=%0b elapsed=%h,",
                     what, cycle_count, exp.fired, exp.elapsed,
                     " got fired=%0b elapsed=%h", got.fired, got.elapsed);
    endtask

    // Applies one accepted word to the shadow table and returns the result it must produce.
    function automatic result_t deadline_table_apply(input cmd_t w);
        result_t            r;
        logic [VALUE_W-1:0] per;
        logic [VALUE_W-1:0] delta;
        r = '0;
        case (w.operation)
            OP_POLL:
            begin
                polls_sent++;
                if (task_enabled[w.task_index])
                begin
                    per = task_period[w.task_index];
                    delta = w.now - task_stamp[w.task_index];
                    if (delta >= per)
                    begin
                        task_stamp[w.task_index] = task_stamp[w.task_index]
                                                   + (delta - (delta % per));
                        r.fired = 1'b1;
                        r.elapsed = delta;
                        fires_predicted++;
                    end
                end
            end
            OP_ENABLE:
            begin
                enables_sent++;
                task_enabled[w.task_index] = w.enable_value;
                task_stamp[w.task_index] = w.now - task_period[w.task_index];
            end
            OP_PERIOD:
            begin
                periods_sent++;
                task_period[w.task_index] = (w.period_value == '0) ? VALUE_W'(1)
                                                                    : w.period_value;
                task_enabled[w.task_index] = w.enable_value;
                task_stamp[w.task_index] = '0;
                period_known[w.task_index] = 1'b1;
            end
            default:
                reserved_sent++;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            results_checked++;
            if (awaited_outcomes.size() == 0)
                log_failure("no command outstanding", '0, result);
            else
            begin
                want = awaited_outcomes.pop_front();
                if (result.fired !== want.fired)
                    log_failure("fired", want, result);
                if (result.elapsed !== want.elapsed)
                    log_failure("elapsed", want, result);
            end
        end
    end

    // An enable write to an entry whose period was never set would read an undefined period.
    task automatic issue_word(input cmd_t w);
        cmd_t word_in;
        word_in = w;
        if (word_in.operation == OP_ENABLE && !period_known[word_in.task_index])
            word_in.operation = OP_PERIOD;
        @(negedge clk);
        start <= 1'b1;
        cmd <= word_in;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        awaited_outcomes.push_back(deadline_table_apply(word_in));
    endtask

    task automatic send_fields(input logic [1:0] op, input int idx, input logic [31:0] at,
                               input bit en, input logic [31:0] per);
        cmd_t w;
        w.operation = op;
        w.task_index = INDEX_W'(idx);
        w.now = at;
        w.enable_value = en;
        w.period_value = per;
        issue_word(w);
    endtask

    task automatic sender_gap(input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 19)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            repeat (gap) @(negedge clk) start <= 1'b0;
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk) start <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_t random_word();
        cmd_t w;
        w.operation = 2'($urandom_range(0, 3));
        w.task_index = INDEX_W'($urandom_range(0, TASKS - 1));
        w.now = $urandom();
        w.enable_value = 1'($urandom_range(0, 1));
        w.period_value = $urandom();
        return w;
    endfunction

    function automatic logic [31:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return $urandom();
        else if (roll < 15)
            return $urandom_range(1000, 100000);
        else
            return $urandom_range(1, 300);
    endfunction

    task automatic test_period_writes();
        send_fields(OP_PERIOD, 0, 32'h1234_5678, 1'b1, 32'h0000_0000);
        send_fields(OP_PERIOD, 15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fields(OP_PERIOD, 5, 32'h0000_0000, 1'b0, 32'd100);
        send_fields(OP_PERIOD, 1, 32'hA5A5_A5A5, 1'b1, 32'd1);
    endtask

    task automatic test_polls();
        send_fields(OP_POLL, 0, 32'h0000_0000, 1'b0, 32'h0);
        send_fields(OP_POLL, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fields(OP_POLL, 0, 32'd5, 1'b0, 32'h0);
        send_fields(OP_POLL, 15, 32'hFFFF_FFFE, 1'b0, 32'h0);
        send_fields(OP_POLL, 15, 32'hFFFF_FFFF, 1'b0, 32'h0);
        send_fields(OP_POLL, 5, 32'd1000, 1'b1, 32'd7);
        send_fields(OP_POLL, 7, 32'd1000, 1'b1, 32'd7);
    endtask

    task automatic test_enable_writes();
        send_fields(OP_ENABLE, 5, 32'd5000, 1'b1, 32'hFFFF_FFFF);
        send_fields(OP_POLL, 5, 32'd5000, 1'b0, 32'h0);
        send_fields(OP_POLL, 5, 32'd5099, 1'b0, 32'h0);
        send_fields(OP_POLL, 5, 32'd5350, 1'b0, 32'h0);
        send_fields(OP_ENABLE, 1, 32'd7, 1'b0, 32'h0);
        send_fields(OP_POLL, 1, 32'd1000, 1'b0, 32'h0);
        send_fields(OP_ENABLE, 15, 32'd3, 1'b1, 32'h0);
        send_fields(OP_POLL, 15, 32'd3, 1'b0, 32'h0);
    endtask

    task automatic test_unused_code();
        send_fields(OP_RESERVED, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fields(OP_POLL, 0, 32'd6, 1'b0, 32'h0);
    endtask

    // Well-formed schedule: a slowly advancing timer, with most words polls of random entries.
    task automatic test_random_schedule(input int count);
        cmd_t w;
        int   roll;
        for (int n = 0; n < count; n++)
        begin
            w = random_word();
            roll = $urandom_range(0, 99);
            if (roll < 65)
                w.operation = OP_POLL;
            else if (roll < 80)
                w.operation = OP_ENABLE;
            else
                w.operation = OP_PERIOD;
            w.now = wall_clock;
            w.enable_value = ($urandom_range(0, 9) != 0);
            w.period_value = pick_period();
            wall_clock = wall_clock + $urandom_range(0, 40);
            if (n == count / 2)
                wait_results_drained();
            sender_gap(n >= count / 4 && n < count / 4 + 400);
            issue_word(w);
        end
    endtask

    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++)
        begin
            sender_gap(1'b0);
            issue_word(random_word());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        for (int i = 0; i < TASKS; i++)
        begin
            task_period[i] = '0;
            task_stamp[i] = '0;
            task_enabled[i] = 1'b0;
            period_known[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_period_writes();
        test_polls();
        wait_results_drained();
        test_enable_writes();
        test_unused_code();
        wait_results_drained();

        wall_clock = 32'hFFFF_8000 + $urandom_range(0, 16'hFFFF);
        test_random_schedule(1600);
        test_random_noise(250);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_outcomes.size() != 0)
            log_failure("result never arrived", awaited_outcomes[0], '0);

        $display("Covered %0d polls (%0d firing), %0d enable writes,",
                 polls_sent, fires_predicted, enables_sent,
                 " %0d period writes, %0d unused codes.", periods_sent, reserved_sent);
        $display("Checked %0d results in %0d cycles; %0d mismatches.",
                 results_checked, cycle_count, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
